// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequent in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tepq_pkg.sv -----
package tepq_pkg;

    localparam int CMD_W  = 2;
    localparam int ID_W   = 5;
    localparam int TIME_W = 64;
    localparam int ST_W   = 2;

    localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REM = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEQ = 2'd2;

    localparam logic [ST_W-1:0] ST_OK         = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY      = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_QUEUED = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL       = 2'd3;

    typedef struct packed {
        logic              occ;
        logic [ID_W-1:0]   ev_id;
        logic [TIME_W-1:0] ev_time;
    } t_cell;

    typedef struct packed {
        logic              rem;
        logic              ins;
        logic [ID_W-1:0]   ev_id;
        logic [TIME_W-1:0] ev_time;
    } t_ctl;

    // 72-bit input transaction, command in the lowest bits
    typedef struct packed {
        logic              pad;
        logic [TIME_W-1:0] ev_time;
        logic [ID_W-1:0]   ev_id;
        logic [CMD_W-1:0]  cmd;
    } t_in;

    // 144-bit result transaction, status in the lowest bits
    typedef struct packed {
        logic [2:0]        pad;
        logic [TIME_W-1:0] head_time;
        logic [ID_W-1:0]   head_id;
        logic              head_valid;
        logic [TIME_W-1:0] pop_time;
        logic [ID_W-1:0]   pop_id;
        logic [ST_W-1:0]   status;
    } t_out;

    localparam int IN_TDATA_W  = $bits(t_in);
    localparam int OUT_TDATA_W = $bits(t_out);

    localparam t_cell CELL_EMPTY = '{occ: 1'b0, ev_id: '0, ev_time: '0};

endpackage

// ----- rtl/tepq_cell.sv -----
module tepq_cell #(
    parameter int INDEX = 0,
    parameter int POS_W = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tepq_pkg::t_ctl     i_ctl,
    input  logic [POS_W-1:0]   i_pos,
    input  tepq_pkg::t_cell    i_left,
    input  logic               i_left_le,
    input  tepq_pkg::t_cell    i_right,
    output tepq_pkg::t_cell    o_cell,
    output logic               o_le,
    output logic               o_match
);

    logic                          r_occ;
    logic [tepq_pkg::ID_W-1:0]     r_id;
    logic [tepq_pkg::TIME_W-1:0]   r_time;
    tepq_pkg::t_cell               n_cell;

    assign o_cell  = '{occ: r_occ, ev_id: r_id, ev_time: r_time};
    assign o_le    = r_occ && (r_time <= i_ctl.ev_time);
    assign o_match = r_occ && (r_id == i_ctl.ev_id);

    always_comb begin
        n_cell = o_cell;
        if (i_ctl.rem && (POS_W'(INDEX) >= i_pos)) begin
            n_cell = i_right;
        end else if (i_ctl.ins && !o_le) begin
            if (i_left_le) begin
                n_cell = '{occ: 1'b1, ev_id: i_ctl.ev_id, ev_time: i_ctl.ev_time};
            end else begin
                n_cell = i_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_cell.occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_cell.ev_id;
        r_time <= n_cell.ev_time;
    end

endmodule

// ----- rtl/tepq_enc.sv -----
module tepq_enc #(
    parameter int N     = 32,
    parameter int POS_W = 5
) (
    input  logic [N-1:0]     i_match,
    output logic [POS_W-1:0] o_pos,
    output logic             o_found
);

    always_comb begin
        logic [POS_W-1:0] idx;
        o_pos = '0;
        for (int i = 0; i < N; i++) begin
            idx   = POS_W'(i);
            o_pos = o_pos | ({POS_W{i_match[i]}} & idx);
        end
    end

    assign o_found = |i_match;

endmodule

// ----- rtl/timed_event_priority_queue_unit.sv -----
// An absent remove, an empty dequeue or an unused command goes from idle straight to the output
// state; other enqueues (full queue too) pass the insert state, removes and dequeues the remove
// state, a re-queue the remove then the insert state. Input is taken only in idle, after the
// output state has registered the last result, held while an earlier one waits on m_axis_tready;
// the chain takes one shift per cycle and a re-queue needs a remove shift then an insert shift.
// Reset: synchronous, active low; empties the chain and drops any pending result.
`include "assert_macros.svh"

module timed_event_priority_queue_unit #(
    parameter int MAX_EVENTS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // command[1:0], event_id[6:2], event_time[70:7], zero[71]
    input  logic [tepq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // status[1:0], popped_id[6:2], popped_time[70:7], head_valid[71],
    // head_id[76:72], head_time[140:77], zero[143:141]
    output logic [tepq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    localparam int POS_W = $clog2(MAX_EVENTS);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_REMOVE = 2'd1;
    localparam logic [1:0] S_INSERT = 2'd2;
    localparam logic [1:0] S_OUT    = 2'd3;

    logic [1:0]                      r_state, n_state;
    logic [tepq_pkg::CMD_W-1:0]      r_cmd, n_cmd;
    logic [tepq_pkg::ID_W-1:0]       r_id, n_id;
    logic [tepq_pkg::TIME_W-1:0]     r_time, n_time;
    logic [POS_W-1:0]                r_pos, n_pos;
    logic [tepq_pkg::ST_W-1:0]       r_status, n_status;
    logic [tepq_pkg::ID_W-1:0]       r_pop_id, n_pop_id;
    logic [tepq_pkg::TIME_W-1:0]     r_pop_time, n_pop_time;
    logic                            r_out_valid, n_out_valid;
    tepq_pkg::t_out                  r_out, n_out;

    tepq_pkg::t_in                   w_in;
    tepq_pkg::t_ctl                  w_ctl;
    tepq_pkg::t_cell                 w_cell [MAX_EVENTS];
    logic [MAX_EVENTS-1:0]           w_le;
    logic [MAX_EVENTS-1:0]           w_match;
    logic [MAX_EVENTS-1:0]           w_occ;
    logic [POS_W-1:0]                w_pos;
    logic                            w_found;
    logic                            w_accept;
    logic                            w_full;

    assign w_in          = tepq_pkg::t_in'(s_axis_tdata);
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_full        = w_cell[MAX_EVENTS-1].occ;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    assign w_ctl.rem     = (r_state == S_REMOVE);
    assign w_ctl.ins     = (r_state == S_INSERT) && !w_full;
    assign w_ctl.ev_id   = (r_state == S_IDLE) ? w_in.ev_id : r_id;
    assign w_ctl.ev_time = r_time;

    for (genvar g = 0; g < MAX_EVENTS; g++) begin : g_cell
        tepq_pkg::t_cell w_l;
        tepq_pkg::t_cell w_r;
        logic            w_lle;

        if (g == 0) begin : g_first
            assign w_l   = tepq_pkg::CELL_EMPTY;
            assign w_lle = 1'b1;
        end else begin : g_mid
            assign w_l   = w_cell[g-1];
            assign w_lle = w_le[g-1];
        end

        if (g == MAX_EVENTS - 1) begin : g_last
            assign w_r = tepq_pkg::CELL_EMPTY;
        end else begin : g_inner
            assign w_r = w_cell[g+1];
        end

        tepq_cell #(
            .INDEX (g),
            .POS_W (POS_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_pos     (r_pos),
            .i_left    (w_l),
            .i_left_le (w_lle),
            .i_right   (w_r),
            .o_cell    (w_cell[g]),
            .o_le      (w_le[g]),
            .o_match   (w_match[g])
        );

        assign w_occ[g] = w_cell[g].occ;
    end

    tepq_enc #(
        .N     (MAX_EVENTS),
        .POS_W (POS_W)
    ) u_enc (
        .i_match (w_match),
        .o_pos   (w_pos),
        .o_found (w_found)
    );

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_id        = r_id;
        n_time      = r_time;
        n_pos       = r_pos;
        n_status    = r_status;
        n_pop_id    = r_pop_id;
        n_pop_time  = r_pop_time;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out       = r_out;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd      = w_in.cmd;
                    n_id       = w_in.ev_id;
                    n_time     = w_in.ev_time;
                    n_status   = tepq_pkg::ST_OK;
                    n_pop_id   = '0;
                    n_pop_time = '0;
                    n_pos      = w_pos;
                    n_state    = S_OUT;
                    case (w_in.cmd)
                        tepq_pkg::CMD_ENQ: begin
                            n_state = w_found ? S_REMOVE : S_INSERT;
                        end
                        tepq_pkg::CMD_REM: begin
                            if (w_found) begin
                                n_state = S_REMOVE;
                            end else begin
                                n_status = tepq_pkg::ST_NOT_QUEUED;
                            end
                        end
                        tepq_pkg::CMD_DEQ: begin
                            n_pos = '0;
                            if (w_cell[0].occ) begin
                                n_pop_id   = w_cell[0].ev_id;
                                n_pop_time = w_cell[0].ev_time;
                                n_state    = S_REMOVE;
                            end else begin
                                n_status = tepq_pkg::ST_EMPTY;
                            end
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_REMOVE: begin
                n_state = (r_cmd == tepq_pkg::CMD_ENQ) ? S_INSERT : S_OUT;
            end
            S_INSERT: begin
                if (w_full) begin
                    n_status = tepq_pkg::ST_FULL;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid      = 1'b1;
                    n_out.pad        = '0;
                    n_out.status     = r_status;
                    n_out.pop_id     = r_pop_id;
                    n_out.pop_time   = r_pop_time;
                    n_out.head_valid = w_cell[0].occ;
                    n_out.head_id    = w_cell[0].occ ? w_cell[0].ev_id : '0;
                    n_out.head_time  = w_cell[0].occ ? w_cell[0].ev_time : '0;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_id       <= n_id;
        r_time     <= n_time;
        r_pos      <= n_pos;
        r_status   <= n_status;
        r_pop_id   <= n_pop_id;
        r_pop_time <= n_pop_time;
        r_out      <= n_out;
    end

    `ASSERT_ALWAYS(a_occ_prefix, i_clk, i_rst_n, (w_occ & (w_occ + 1'b1)) == '0, "occupied cells not a prefix")
    `ASSERT_ALWAYS(a_unique_handle, i_clk, i_rst_n, $onehot0(w_match), "handle held by more than one cell")
    `ASSERT_NEXT(a_remove_count, i_clk, i_rst_n, r_state == S_REMOVE, $countones(w_occ) == $countones($past(w_occ)) - 1, "remove did not drop one entry")
    `ASSERT_NEXT(a_insert_count, i_clk, i_rst_n, r_state == S_INSERT && !w_full, $countones(w_occ) == $countones($past(w_occ)) + 1, "insert did not add one entry")

endmodule
